// File: sv/assert_macros.svh
// Assertion macros shared by the RTL of the score propagation unit.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property that must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// condition that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: sv/ssp_pkg.sv
// Shared types and constants of the signed score propagation unit.
// Used by the controller, the datapath and the top level.
`default_nettype none
package ssp_pkg;

    localparam int IDX_W    = 10;
    localparam int MAX_NODES = 2 ** IDX_W;
    localparam int CNT_W    = IDX_W + 1;
    localparam int SEED_W   = 10;
    localparam int ITER_W   = 8;
    localparam int BETA_W   = 17;
    localparam int W_BITS   = 16;
    localparam int S_BITS   = 32;
    localparam int WFRAC    = W_BITS - 2;
    localparam int SFRAC    = 16;
    localparam int MUL_A_W  = BETA_W + 1;
    localparam int MUL_W    = MUL_A_W + S_BITS;
    localparam int ACC_W    = 64;
    localparam int SUM_W    = 48;
    localparam int DIV_W    = S_BITS + SFRAC;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0]  NODE_COUNT_RST = CNT_W'(863);
    localparam logic [SEED_W-1:0] SEED_COUNT_RST = SEED_W'(60);
    localparam logic [ITER_W-1:0] ITER_RST       = ITER_W'(50);
    localparam logic [BETA_W-1:0] BETA_ONE       = BETA_W'(65536);

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_BETA   = 2'd3;

    typedef enum logic [1:0] {
        OP_WR_WEIGHT = 2'd0,
        OP_WR_SCORE  = 2'd1,
        OP_RUN       = 2'd2,
        OP_RD_SCORE  = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RESP, ST_RUN, ST_ROW, ST_RD, ST_MUL, ST_ACC, ST_WROW,
        ST_PASS, ST_MIX_RD, ST_MIX_A, ST_MIX_B, ST_MIX_W,
        ST_SCL_RD, ST_SCL_DIV, ST_SCL_WAIT, ST_PASS_END
    } t_state;

    typedef enum logic [1:0] {
        MUL_MAC, MUL_SEED, MUL_SCORE
    } t_mul_sel;

    typedef enum logic [1:0] {
        SRC_J, SRC_I, SRC_IN
    } t_ssrc;

    typedef struct packed {
        logic             ld_weight;
        logic             ld_score;
        logic             w_rd;
        logic             s_rd;
        t_ssrc            s_src;
        logic             p_rd;
        logic             mul_en;
        t_mul_sel         mul_sel;
        logic             hold_en;
        logic             acc_clr;
        logic             acc_add;
        logic             seed_we;
        logic             prod_we;
        logic             mix_we;
        logic             sum_clr;
        logic             div_start;
        logic             scale_we;
        logic             out_load;
        t_op              out_op;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

endpackage
`default_nettype wire

// File: sv/signed_score_propagation_unit.sv
// Signed score propagation over a similarity matrix.
// Input words on the s side (tuser = op, tdata = row, col, weight, score),
// one result word per input on the m side (tdata = score, index; tuser = done).
// Weight and score loads and score reads are accepted in the idle state; their
// result then moves into the output register from the response state.
// A run word holds the input side for the whole computation, a seed phase
// and then the passes, which run on the single multiply-accumulate path and
// the bit-per-cycle divider, and then returns run_done = 1.
// The output register holds a word until i_m_tready; the next input word is
// taken while it waits, and its result is held back, with no further word
// taken, until the register frees. Reset is synchronous and active low: it
// restores the configuration defaults and clears control state; the weight
// and score memories are undefined until written.
// Depends on ssp_pkg, ssp_ctrl, ssp_dp and ssp_div.
`default_nettype none
module signed_score_propagation_unit
    import ssp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // row[9:0], col[19:10], weight_value[35:20], score_value[67:36], zero pad
    input  wire logic [71:0]          i_s_tdata,
    // op[1:0]
    input  wire logic [1:0]           i_s_tuser,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // score_out[31:0], node_index[41:32], zero pad
    output logic [47:0]               o_m_tdata,
    // run_done[0]
    output logic                      o_m_tuser
);

    t_cmd              cmd;
    t_stat             stat;
    logic [S_BITS-1:0] score_out;
    logic [IDX_W-1:0]  index_out;

    ssp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_op      (i_s_tuser),
        .i_m_tready  (i_m_tready),
        .i_stat      (stat),
        .o_s_tready  (o_s_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_cmd       (cmd)
    );

    ssp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_row       (i_s_tdata[9:0]),
        .i_col       (i_s_tdata[19:10]),
        .i_weight    (i_s_tdata[35:20]),
        .i_score     (i_s_tdata[67:36]),
        .o_stat      (stat),
        .o_score     (score_out),
        .o_index     (index_out),
        .o_done      (o_m_tuser)
    );

    assign o_m_tdata = {6'b0, index_out, score_out};

endmodule
`default_nettype wire

// File: sv/ssp_div.sv
// Restoring divider, one quotient bit per cycle, for the score scaling step.
// Depends on ssp_pkg for widths.
`default_nettype none
module ssp_div
    import ssp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [SUM_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quot
);

    localparam int DCNT_W = $clog2(DIV_W);

    logic [SUM_W:0]      r_rem;
    logic [DIV_W-1:0]    r_quo;
    logic [SUM_W-1:0]    r_den;
    logic [DCNT_W-1:0]   r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [SUM_W:0] rem_sh;
    logic [SUM_W:0] diff;

    assign rem_sh = {r_rem[SUM_W-1:0], r_quo[DIV_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DCNT_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            // keep the difference when it does not borrow
            if (!diff[SUM_W]) begin
                r_rem <= diff;
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
`default_nettype wire

// File: sv/ssp_dp.sv
// Datapath: weight, score and seed memories, shared multiplier, accumulator,
// mixing, sums and scaling. Depends on ssp_pkg and ssp_div.
`default_nettype none
module ssp_dp
    import ssp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic [IDX_W-1:0]     i_row,
    input  wire logic [IDX_W-1:0]     i_col,
    input  wire logic [W_BITS-1:0]    i_weight,
    input  wire logic [S_BITS-1:0]    i_score,
    output t_stat                     o_stat,
    output logic [S_BITS-1:0]         o_score,
    output logic [IDX_W-1:0]          o_index,
    output logic                      o_done
);

    localparam logic signed [ACC_W-1:0] S_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] S_MIN = -ACC_W'(64'sd2147483648);

    function automatic logic signed [S_BITS-1:0] sat_s(input logic signed [ACC_W-1:0] x);
        logic signed [S_BITS-1:0] r;
        if (x > S_MAX) r = S_MAX[S_BITS-1:0];
        else if (x < S_MIN) r = S_MIN[S_BITS-1:0];
        else r = x[S_BITS-1:0];
        return r;
    endfunction

    logic signed [W_BITS-1:0] mem_w [0:MAX_NODES*MAX_NODES-1];
    logic signed [S_BITS-1:0] mem_s [0:MAX_NODES-1];
    logic signed [S_BITS-1:0] mem_p [0:MAX_NODES-1];

    logic signed [W_BITS-1:0] r_w_rd;
    logic signed [S_BITS-1:0] r_s_rd;
    logic signed [S_BITS-1:0] r_p_rd;
    logic signed [MUL_W-1:0]  r_mul;
    logic signed [MUL_W-1:0]  r_hold;
    logic signed [ACC_W-1:0]  r_acc;
    logic [SUM_W-1:0]         r_pos_sum;
    logic [SUM_W-1:0]         r_neg_sum;
    logic [BETA_W-1:0]        r_beta;
    logic [IDX_W-1:0]         r_row;
    logic                     r_neg;
    logic                     r_keep;
    logic [S_BITS-1:0]        r_out_score;
    logic [IDX_W-1:0]         r_out_index;
    logic                     r_out_done;

    logic [IDX_W-1:0]         s_addr;
    logic [BETA_W-1:0]        beta_eff;
    logic [BETA_W-1:0]        one_minus;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [S_BITS-1:0] mul_b;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [S_BITS-1:0] prod_res;
    logic signed [ACC_W-1:0]  mix_sum;
    logic signed [S_BITS-1:0] mix_res;
    logic [S_BITS:0]          mag;
    logic [S_BITS:0]          mix_mag;
    logic [SUM_W-1:0]         divisor;
    logic                     div_done;
    logic [DIV_W-1:0]         quot;
    logic [S_BITS-1:0]        q_sat;
    logic signed [S_BITS-1:0] scale_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta <= '0;
        end else if (i_cfg_we && i_cfg_index == CFG_MIX_BETA) begin
            r_beta <= i_cfg_data[BETA_W-1:0];
        end
    end

    assign beta_eff  = (r_beta > BETA_ONE) ? BETA_ONE : r_beta;
    assign one_minus = BETA_ONE - beta_eff;

    always_comb begin
        case (i_cmd.s_src)
            SRC_J:   s_addr = i_cmd.j;
            SRC_IN:  s_addr = i_row;
            default: s_addr = i_cmd.i;
        endcase
    end

    // weight memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_weight) mem_w[{i_row, i_col}] <= i_weight;
        if (i_cmd.w_rd) r_w_rd <= mem_w[{i_cmd.i, i_cmd.j}];
    end

    // seed contribution memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_we) mem_p[i_cmd.i] <= prod_res;
        if (i_cmd.p_rd) r_p_rd <= mem_p[i_cmd.i];
    end

    // score memory, single write port shared by load, product, mix and scale
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_score) mem_s[i_row] <= i_score;
        else if (i_cmd.prod_we) mem_s[i_cmd.i] <= prod_res;
        else if (i_cmd.mix_we) mem_s[i_cmd.i] <= mix_res;
        else if (i_cmd.scale_we) mem_s[i_cmd.i] <= scale_res;
        if (i_cmd.s_rd) r_s_rd <= mem_s[s_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.s_rd && i_cmd.s_src == SRC_IN) r_row <= i_row;
    end

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SEED: begin
                mul_a = {1'b0, one_minus};
                mul_b = r_p_rd;
            end
            MUL_SCORE: begin
                mul_a = {1'b0, beta_eff};
                mul_b = r_s_rd;
            end
            default: begin
                mul_a = MUL_A_W'(r_w_rd);
                mul_b = r_s_rd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) r_mul <= mul_a * mul_b;
        if (i_cmd.hold_en) r_hold <= r_mul;
        if (i_cmd.acc_clr) r_acc <= '0;
        else if (i_cmd.acc_add) r_acc <= r_acc + ACC_W'(r_mul);
    end

    assign acc_rnd  = (r_acc + ACC_W'(64'sd1 <<< (WFRAC - 1))) >>> WFRAC;
    assign prod_res = sat_s(acc_rnd);

    assign mix_sum  = (ACC_W'(r_hold) + ACC_W'(r_mul) + ACC_W'(64'sd1 <<< (SFRAC - 1)))
                      >>> SFRAC;
    assign mix_res  = sat_s(mix_sum);
    assign mix_mag  = -{mix_res[S_BITS-1], mix_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.sum_clr) begin
            r_pos_sum <= '0;
            r_neg_sum <= '0;
        end else if (i_cmd.mix_we) begin
            if (!mix_res[S_BITS-1] && mix_res != '0)
                r_pos_sum <= r_pos_sum + SUM_W'(mix_res);
            else if (mix_res[S_BITS-1])
                r_neg_sum <= r_neg_sum + SUM_W'(mix_mag);
        end
    end

    // scaling: |score| << 16 divided by the sum of its own sign
    assign mag     = r_s_rd[S_BITS-1] ? -{1'b1, r_s_rd} : {1'b0, r_s_rd};
    assign divisor = r_s_rd[S_BITS-1] ? r_neg_sum : r_pos_sum;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg  <= r_s_rd[S_BITS-1];
            r_keep <= (r_s_rd == '0) || (divisor == '0);
        end
    end

    ssp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({mag[S_BITS-1:0], {SFRAC{1'b0}}}),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign q_sat     = (quot > DIV_W'(S_MAX[S_BITS-1:0])) ? S_MAX[S_BITS-1:0]
                                                          : quot[S_BITS-1:0];
    assign scale_res = r_keep ? r_s_rd : (r_neg ? -q_sat : q_sat);

    assign o_stat.div_done = div_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_op)
                OP_RD_SCORE: begin
                    r_out_score <= r_s_rd;
                    r_out_index <= r_row;
                    r_out_done  <= 1'b0;
                end
                OP_RUN: begin
                    r_out_score <= '0;
                    r_out_index <= '0;
                    r_out_done  <= 1'b1;
                end
                default: begin
                    r_out_score <= '0;
                    r_out_index <= '0;
                    r_out_done  <= 1'b0;
                end
            endcase
        end
    end

    assign o_score = r_out_score;
    assign o_index = r_out_index;
    assign o_done  = r_out_done;

endmodule
`default_nettype wire

// File: sv/ssp_ctrl.sv
// Controller: configuration registers, loop counters and the run sequencer.
// Depends on ssp_pkg; drives the datapath through t_cmd.
`default_nettype none
`include "assert_macros.svh"
module ssp_ctrl
    import ssp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_s_tvalid,
    input  wire logic [1:0]           i_s_op,
    input  wire logic                 i_m_tready,
    input  wire t_stat                i_stat,
    output logic                      o_s_tready,
    output logic                      o_m_tvalid,
    output t_cmd                      o_cmd
);

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_node_count;
    logic [SEED_W-1:0] r_seed_count;
    logic [ITER_W-1:0] r_iter_count;
    logic [IDX_W-1:0]  r_i;
    logic [IDX_W-1:0]  r_j;
    logic [ITER_W-1:0] r_pass;
    logic              r_prod;
    t_op               r_op;
    logic              r_out_valid;

    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] s_eff;
    logic             accept;
    logic             last_i;
    logic             last_j;
    logic             no_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            r_seed_count <= SEED_COUNT_RST;
            r_iter_count <= ITER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NODE_COUNT: r_node_count <= i_cfg_data[CNT_W-1:0];
                CFG_SEED_COUNT: r_seed_count <= i_cfg_data[SEED_W-1:0];
                CFG_ITER_COUNT: r_iter_count <= i_cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    assign n_eff   = (r_node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : r_node_count;
    assign s_eff   = (CNT_W'(r_seed_count) > n_eff) ? n_eff : CNT_W'(r_seed_count);
    assign no_free = (s_eff >= n_eff);
    assign accept  = i_s_tvalid && (r_state == ST_IDLE);
    assign last_i  = ({1'b0, r_i} == n_eff - 1'b1);
    assign last_j  = r_prod ? ({1'b0, r_j} == n_eff - 1'b1) : ({1'b0, r_j} == s_eff - 1'b1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (accept) n_state = (t_op'(i_s_op) == OP_RUN) ? ST_RUN : ST_RESP;
            ST_RUN:      n_state = no_free ? ST_PASS : ST_ROW;
            ST_ROW:      n_state = (!r_prod && s_eff == '0) ? ST_WROW : ST_RD;
            ST_RD:       n_state = ST_MUL;
            ST_MUL:      n_state = ST_ACC;
            ST_ACC:      n_state = last_j ? ST_WROW : ST_RD;
            ST_WROW: begin
                if (!last_i) n_state = ST_ROW;
                else n_state = r_prod ? ST_MIX_RD : ST_PASS;
            end
            ST_PASS: begin
                if (r_pass == r_iter_count) n_state = ST_RESP;
                else n_state = no_free ? ST_PASS_END : ST_ROW;
            end
            ST_MIX_RD:   n_state = ST_MIX_A;
            ST_MIX_A:    n_state = ST_MIX_B;
            ST_MIX_B:    n_state = ST_MIX_W;
            ST_MIX_W:    n_state = last_i ? ST_SCL_RD : ST_MIX_RD;
            ST_SCL_RD:   n_state = ST_SCL_DIV;
            ST_SCL_DIV:  n_state = ST_SCL_WAIT;
            ST_SCL_WAIT: if (i_stat.div_done) n_state = last_i ? ST_PASS_END : ST_SCL_RD;
            ST_PASS_END: n_state = ST_PASS;
            ST_RESP:     if (!r_out_valid || i_m_tready) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.i      = r_i;
        o_cmd.j      = r_j;
        o_cmd.out_op = r_op;
        o_s_tready   = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_op'(i_s_op))
                        OP_WR_WEIGHT: o_cmd.ld_weight = 1'b1;
                        OP_WR_SCORE:  o_cmd.ld_score  = 1'b1;
                        OP_RD_SCORE: begin
                            o_cmd.s_rd  = 1'b1;
                            o_cmd.s_src = SRC_IN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ROW:  o_cmd.acc_clr = 1'b1;
            ST_RD: begin
                o_cmd.w_rd  = 1'b1;
                o_cmd.s_rd  = 1'b1;
                o_cmd.s_src = SRC_J;
            end
            ST_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_MAC;
            end
            ST_ACC:  o_cmd.acc_add = 1'b1;
            ST_WROW: begin
                o_cmd.prod_we = r_prod;
                o_cmd.seed_we = !r_prod;
            end
            ST_PASS: o_cmd.sum_clr = (r_pass != r_iter_count);
            ST_MIX_RD: begin
                o_cmd.p_rd  = 1'b1;
                o_cmd.s_rd  = 1'b1;
                o_cmd.s_src = SRC_I;
            end
            ST_MIX_A: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SEED;
            end
            ST_MIX_B: begin
                o_cmd.hold_en = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SCORE;
            end
            ST_MIX_W: o_cmd.mix_we = 1'b1;
            ST_SCL_RD: begin
                o_cmd.s_rd  = 1'b1;
                o_cmd.s_src = SRC_I;
            end
            ST_SCL_DIV:  o_cmd.div_start = 1'b1;
            ST_SCL_WAIT: o_cmd.scale_we  = i_stat.div_done;
            ST_RESP:     o_cmd.out_load  = !r_out_valid || i_m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_op        <= OP_WR_WEIGHT;
            r_i         <= '0;
            r_j         <= '0;
            r_pass      <= '0;
            r_prod      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (accept) r_op <= t_op'(i_s_op);
                ST_RUN: begin
                    r_i    <= s_eff[IDX_W-1:0];
                    r_pass <= '0;
                    r_prod <= 1'b0;
                end
                ST_ROW: r_j <= r_prod ? s_eff[IDX_W-1:0] : '0;
                ST_ACC: if (!last_j) r_j <= r_j + 1'b1;
                ST_WROW: r_i <= last_i ? s_eff[IDX_W-1:0] : r_i + 1'b1;
                ST_PASS: begin
                    r_i    <= s_eff[IDX_W-1:0];
                    r_prod <= 1'b1;
                end
                ST_MIX_W: r_i <= last_i ? s_eff[IDX_W-1:0] : r_i + 1'b1;
                ST_SCL_WAIT: begin
                    if (i_stat.div_done) r_i <= last_i ? s_eff[IDX_W-1:0] : r_i + 1'b1;
                end
                ST_PASS_END: r_pass <= r_pass + 1'b1;
                default: ;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;

    `ASSERT_AT(a_accept_leaves_idle, i_clk, i_rst_n, accept |=> (r_state != ST_IDLE))
    `ASSERT_AT(a_load_from_resp, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state) == ST_RESP)
    `ASSERT_NEVER(a_row_in_range, i_clk, i_rst_n, (r_state == ST_ACC) && ({1'b0, r_i} >= n_eff))

endmodule
`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for the signed score propagation unit.
// Drives load, run and read words, predicts every result word, checks them in order.
// Depends on ssp_pkg and signed_score_propagation_unit.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import ssp_pkg::*;

    typedef struct packed {
        logic [31:0] score;
        logic [9:0]  idx;
        logic        done;
    } t_result;

    typedef struct {
        t_op         op;
        logic [9:0]  row;
        logic [9:0]  col;
        logic [15:0] wv;
        logic [31:0] sv;
        bit          typed;
        t_result     res;
    } t_vec;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [71:0]       i_s_tdata = '0;
    logic [1:0]        i_s_tuser = '0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [47:0]       o_m_tdata;
    logic              o_m_tuser;

    signed_score_propagation_unit uut (.*);

    always #6 i_clk = ~i_clk;

    // model of the block's state
    shortint     weight_mem [MAX_NODES*MAX_NODES];
    bit          weight_set [MAX_NODES*MAX_NODES];
    longint      score_mem  [MAX_NODES];
    bit          score_set  [MAX_NODES];
    longint      seed_mem   [MAX_NODES];
    int unsigned node_cnt = 863, seed_cnt = 60, iter_cnt = 50, beta_val = 0;

    t_result     pending [$];
    int          errors = 0;
    int          burst_left = 0;

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint round_prod(longint acc);
        return clamp32((acc + 64'sd8192) >>> 14);
    endfunction

    function automatic longint scale_score(longint v, longint unsigned total);
        longint unsigned mag, q;
        if (total == 0) return v;
        mag = v < 0 ? longint'(-v) : longint'(v);
        q = (mag << 16) / total;
        if (q > 64'd2147483647) q = 64'd2147483647;
        return v < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic void propagate();
        int unsigned n, s, p, i, j;
        longint beta, acc, m;
        longint unsigned pos_sum, neg_sum;
        n = node_cnt > MAX_NODES ? MAX_NODES : node_cnt;
        s = seed_cnt > n ? n : seed_cnt;
        beta = beta_val > 65536 ? 65536 : beta_val;
        for (i = s; i < n; i++) begin
            acc = 0;
            for (j = 0; j < s; j++)
                acc += longint'(weight_mem[i*MAX_NODES+j]) * score_mem[j];
            seed_mem[i] = round_prod(acc);
        end
        for (p = 0; p < iter_cnt; p++) begin
            // rows see the already updated scores of earlier rows
            for (i = s; i < n; i++) begin
                acc = 0;
                for (j = s; j < n; j++)
                    acc += longint'(weight_mem[i*MAX_NODES+j]) * score_mem[j];
                score_mem[i] = round_prod(acc);
            end
            for (i = s; i < n; i++) begin
                m = (65536 - beta) * seed_mem[i] + beta * score_mem[i] + 32768;
                score_mem[i] = clamp32(m >>> 16);
            end
            pos_sum = 0;
            neg_sum = 0;
            for (i = s; i < n; i++) begin
                if (score_mem[i] > 0) pos_sum += score_mem[i];
                else if (score_mem[i] < 0) neg_sum += -score_mem[i];
            end
            for (i = s; i < n; i++) begin
                if (score_mem[i] > 0) score_mem[i] = scale_score(score_mem[i], pos_sum);
                else if (score_mem[i] < 0) score_mem[i] = scale_score(score_mem[i], neg_sum);
            end
        end
        for (i = s; i < n; i++) score_set[i] = 1'b1;
    endfunction

    function automatic t_result predict_word(t_vec v);
        t_result r;
        r = '0;
        case (v.op)
            OP_WR_WEIGHT: begin
                weight_mem[v.row*MAX_NODES+v.col] = shortint'(v.wv);
                weight_set[v.row*MAX_NODES+v.col] = 1'b1;
            end
            OP_WR_SCORE: begin
                score_mem[v.row] = longint'(signed'(v.sv));
                score_set[v.row] = 1'b1;
            end
            OP_RUN: begin
                propagate();
                r.done = 1'b1;
            end
            default: begin
                r.idx = v.row;
                r.score = score_mem[v.row][31:0];
            end
        endcase
        return r;
    endfunction

    // hand one word to the block; inputs move at the falling edge
    task automatic send_word(t_vec v);
        t_result r;
        int gap;
        if (burst_left == 0) begin
            i_s_tvalid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_s_tvalid = 1'b1;
        i_s_tuser = v.op;
        i_s_tdata = {4'b0, v.sv, v.wv, v.col, v.row};
        do @(posedge i_clk); while (!o_s_tready);
        r = predict_word(v);
        pending.push_back(v.typed ? v.res : r);
        @(negedge i_clk);
    endtask

    function automatic t_vec mk(t_op op, int row, int col, int wv, int sv);
        t_vec v;
        v.op = op;
        v.row = 10'(row);
        v.col = 10'(col);
        v.wv = 16'(wv);
        v.sv = 32'(sv);
        v.typed = 1'b0;
        v.res = '0;
        return v;
    endfunction

    function automatic t_vec rand_load(int n);
        int lim;
        lim = ($urandom_range(0, 7) == 0) ? 1023 : n - 1;
        if ($urandom_range(0, 1))
            return mk(OP_WR_WEIGHT, $urandom_range(0, lim), $urandom_range(0, lim),
                      ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32767) - 16384,
                      $urandom);
        return mk(OP_WR_SCORE, $urandom_range(0, lim), $urandom, $urandom,
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 262143) - 131072);
    endfunction

    task automatic set_reg(logic [1:0] idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_NODE_COUNT: node_cnt = val & 32'h7FF;
            CFG_SEED_COUNT: seed_cnt = val & 32'h3FF;
            CFG_ITER_COUNT: iter_cnt = val & 32'hFF;
            default:        beta_val = val & 32'h1FFFF;
        endcase
    endtask

    task automatic drain();
        i_s_tvalid = 1'b0;
        burst_left = 0;
        wait (pending.size() == 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic configure(int unsigned n, int unsigned s, int unsigned it, int unsigned b);
        drain();
        set_reg(CFG_NODE_COUNT, n);
        set_reg(CFG_SEED_COUNT, s);
        set_reg(CFG_ITER_COUNT, it);
        set_reg(CFG_MIX_BETA, b);
    endtask

    // write every entry a run will touch that is still unwritten
    task automatic fill_missing();
        int unsigned n, s;
        n = node_cnt > MAX_NODES ? MAX_NODES : node_cnt;
        s = seed_cnt > n ? n : seed_cnt;
        for (int j = 0; j < n; j++)
            if (!score_set[j])
                send_word(mk(OP_WR_SCORE, j, 0, 0, $urandom_range(0, 131072) - 65536));
        for (int i = s; i < n; i++)
            for (int j = 0; j < n; j++)
                if (!weight_set[i*MAX_NODES+j])
                    send_word(mk(OP_WR_WEIGHT, i, j, $urandom_range(0, 32767) - 16384, 0));
    endtask

    task automatic random_phase(int n, int items);
        t_vec v;
        int r;
        fill_missing();
        for (int k = 0; k < items; k++) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
                fill_missing();
                v = mk(OP_RUN, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 8) begin
                r = $urandom_range(0, 1023);
                if (!score_set[r]) r = $urandom_range(0, n - 1);
                if (!score_set[r]) r = 0;
                v = mk(OP_RD_SCORE, r, $urandom, $urandom, $urandom);
            end else begin
                v = rand_load(n);
            end
            send_word(v);
        end
        fill_missing();
        send_word(mk(OP_RUN, 0, 0, 0, 0));
        for (int j = 0; j < n && j < 16; j++)
            send_word(mk(OP_RD_SCORE, j, 0, 0, 0));
    endtask

    // receiver: switch between always ready, random and mostly stalled
    int stall_mode = 0, stall_cnt = 0;
    always @(negedge i_clk) begin
        if (stall_cnt == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_cnt = $urandom_range(8, 80);
        end
        stall_cnt--;
        case (stall_mode)
            0: i_m_tready = 1'b1;
            1: i_m_tready = $urandom_range(0, 1);
            default: i_m_tready = ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.score = o_m_tdata[31:0];
            got.idx = o_m_tdata[41:32];
            got.done = o_m_tuser;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word: %h", got);
            end else begin
                want = pending.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: score %h/%h idx %0d/%0d done %b/%b (exp/act)",
                                 want.score, got.score, want.idx, got.idx,
                                 want.done, got.done);
                end
            end
        end
    end

    initial begin
        #60_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    t_vec dir [$];

    initial begin
        t_vec v;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        configure(4, 2, 1, 65536);
        // extremes of weight and score; the scores are read back at a glance
        dir.push_back(mk(OP_WR_SCORE, 0, 0, 0, 32'h7FFFFFFF));
        dir.push_back(mk(OP_WR_SCORE, 1, 0, 0, 32'h80000000));
        dir.push_back(mk(OP_WR_SCORE, 2, 0, 0, 32'h00010000));
        dir.push_back(mk(OP_WR_SCORE, 3, 0, 0, 32'hFFFF0000));
        dir.push_back(mk(OP_WR_WEIGHT, 2, 0, 16'h7FFF, 0));
        dir.push_back(mk(OP_WR_WEIGHT, 2, 1, 16'h8000, 0));
        dir.push_back(mk(OP_WR_WEIGHT, 2, 2, 16'h4000, 0));
        dir.push_back(mk(OP_WR_WEIGHT, 2, 3, 16'hC000, 0));
        dir.push_back(mk(OP_WR_WEIGHT, 3, 0, 16'h0001, 0));
        dir.push_back(mk(OP_WR_WEIGHT, 3, 1, 16'hFFFF, 0));
        dir.push_back(mk(OP_WR_WEIGHT, 3, 2, 16'h2000, 0));
        dir.push_back(mk(OP_WR_WEIGHT, 3, 3, 16'h7FFF, 0));
        dir.push_back(mk(OP_WR_WEIGHT, 1023, 1023, 16'h1234, 0));
        dir.push_back(mk(OP_WR_SCORE, 1023, 1023, 16'hFFFF, 32'h12345678));
        v = mk(OP_RD_SCORE, 0, 0, 0, 0);
        v.typed = 1'b1;
        v.res = '{32'h7FFFFFFF, 10'd0, 1'b0};
        dir.push_back(v);
        v = mk(OP_RD_SCORE, 1, 0, 0, 0);
        v.typed = 1'b1;
        v.res = '{32'h80000000, 10'd1, 1'b0};
        dir.push_back(v);
        v = mk(OP_RD_SCORE, 1023, 0, 0, 0);
        v.typed = 1'b1;
        v.res = '{32'h12345678, 10'd1023, 1'b0};
        dir.push_back(v);
        dir.push_back(mk(OP_RUN, 5, 5, 5, 5));
        dir.push_back(mk(OP_RD_SCORE, 2, 0, 0, 0));
        dir.push_back(mk(OP_RD_SCORE, 3, 0, 0, 0));
        dir.push_back(mk(OP_RD_SCORE, 0, 0, 0, 0));
        foreach (dir[k]) send_word(dir[k]);

        // no non-seed node: seeds above the node count
        configure(3, 1023, 2, 0);
        fill_missing();
        send_word(mk(OP_RUN, 0, 0, 0, 0));
        send_word(mk(OP_RD_SCORE, 2, 0, 0, 0));

        configure(2, 1, 1, 0);
        random_phase(2, 60);
        configure(6, 2, 255, 131071);
        random_phase(6, 60);
        for (int ph = 0; ph < 10; ph++) begin
            int n;
            n = $urandom_range(2, 10);
            configure(n, $urandom_range(1, n), $urandom_range(1, 6), $urandom_range(0, 70000));
            random_phase(n, 110);
        end
        // largest node count, clipped to the memory size, one free node
        configure(2047, 1023, 255, 65536);
        random_phase(1024, 20);

        drain();
        repeat (20) @(negedge i_clk);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+sv
sv/ssp_pkg.sv
sv/ssp_div.sv
sv/ssp_dp.sv
sv/ssp_ctrl.sv
sv/signed_score_propagation_unit.sv
bench/tb.sv
